// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the serial frame receiver: phase and status
// codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int ByteW      = 8;
    localparam int CfgIndexW  = 2;
    localparam int StatusW    = 2;
    localparam int ResDataW   = 112;

    // Register reset values
    localparam logic [ByteW-1:0] DefMaxLen = 8'd64;
    localparam logic [ByteW-1:0] DefStart  = 8'hFD;
    localparam logic [ByteW-1:0] DefEnd    = 8'hFE;

    // Shortest length byte that still holds start, length, checksum and end
    localparam logic [ByteW-1:0] MinLen    = 8'd4;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_START   = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_END     = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_END = 2'd1,
        ST_BAD_SUM = 2'd2,
        ST_BAD_LEN = 2'd3
    } status_t;

    typedef struct packed {
        logic [ByteW-1:0] max_frame_len;
        logic [ByteW-1:0] start_byte;
        logic [ByteW-1:0] end_byte;
    } cfg_t;

    typedef struct packed {
        status_t          frame_status;
        logic [ByteW-1:0] frame_len;
        logic [ByteW-1:0] command;
        logic [ByteW-1:0] ret_code;
        logic [31:0]      version;
        logic [ByteW-1:0] func_id;
        logic [15:0]      label_id;
        logic [ByteW-1:0] box_x;
        logic [ByteW-1:0] box_y;
        logic [ByteW-1:0] box_w;
        logic [ByteW-1:0] box_h;
    } result_t;

endpackage

// ===== design/sfr_deframer.sv =====
// ----------------------------------------------------------------------------
// sfr_deframer
// Frame parser: hunts for the start byte, checks length, sums the body,
// captures fields at fixed offsets and reports one result at frame end or on a bad length byte.
// ----------------------------------------------------------------------------
module sfr_deframer
    import sfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [ByteW-1:0] rx_byte,
    input  cfg_t             cfg,
    output logic             res_valid,
    output result_t          res
);

    phase_t           phase_reg, phase_next;
    logic [ByteW-1:0] index_reg, index_next;
    logic [ByteW-1:0] exp_len_reg, exp_len_next;
    logic [ByteW-1:0] sum_reg, sum_next;
    logic             matched_reg, matched_next;
    logic [ByteW-1:0] command_reg, command_next;
    logic [ByteW-1:0] ret_code_reg, ret_code_next;
    logic [31:0]      version_reg, version_next;
    logic [ByteW-1:0] func_id_reg, func_id_next;
    logic [15:0]      label_id_reg, label_id_next;
    logic [ByteW-1:0] box_reg  [4];
    logic [ByteW-1:0] box_next [4];

    logic [ByteW:0]   idx_p1;
    logic [ByteW:0]   idx_p2;
    logic [ByteW:0]   idx_p3;
    logic [ByteW:0]   n_ext;
    status_t          status;

    assign idx_p1 = {1'b0, index_reg} + 9'd1;
    assign idx_p2 = {1'b0, index_reg} + 9'd2;
    assign idx_p3 = {1'b0, index_reg} + 9'd3;
    assign n_ext  = {1'b0, exp_len_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        exp_len_next  = exp_len_reg;
        sum_next      = sum_reg;
        matched_next  = matched_reg;
        command_next  = command_reg;
        ret_code_next = ret_code_reg;
        version_next  = version_reg;
        func_id_next  = func_id_reg;
        label_id_next = label_id_reg;
        for (int k = 0; k < 4; k++)
        begin
            box_next[k] = box_reg[k];
        end
        res_valid = 1'b0;
        status    = ST_OK;

        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.start_byte)
                begin
                    command_next  = '0;
                    ret_code_next = '0;
                    version_next  = '0;
                    func_id_next  = '0;
                    label_id_next = '0;
                    for (int k = 0; k < 4; k++)
                    begin
                        box_next[k] = '0;
                    end
                    sum_next     = '0;
                    matched_next = 1'b0;
                    index_next   = 8'd1;
                    exp_len_next = '0;
                    phase_next   = PH_LEN;
                end
            end
            PH_LEN:
            begin
                exp_len_next = rx_byte;
                if (rx_byte > cfg.max_frame_len || rx_byte < MinLen)
                begin
                    res_valid  = 1'b1;
                    status     = ST_BAD_LEN;
                    phase_next = PH_HUNT;
                    index_next = '0;
                end
                else
                begin
                    sum_next   = rx_byte;
                    index_next = 8'd2;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                // Capture the byte at its fixed offset
                case (index_reg) inside
                    8'd2:        command_next  = rx_byte;
                    8'd3:        ret_code_next = rx_byte;
                    [8'd4:8'd7]: version_next[8*index_reg[1:0] +: 8] =
                                     version_reg[8*index_reg[1:0] +: 8] | rx_byte;
                    8'd8:        func_id_next  = rx_byte;
                    8'd10:       label_id_next[7:0]  = rx_byte;
                    8'd11:       label_id_next[15:8] = rx_byte;
                    [8'd12:8'd15]: box_next[index_reg[1:0]] = rx_byte;
                    default:     ;
                endcase

                if (idx_p3 <= n_ext)
                begin
                    sum_next = sum_reg + rx_byte;
                end
                else if (idx_p2 == n_ext)
                begin
                    matched_next = (sum_reg == rx_byte);
                end

                if (idx_p1 >= n_ext)
                begin
                    res_valid  = 1'b1;
                    if (rx_byte != cfg.end_byte)
                    begin
                        status = ST_BAD_END;
                    end
                    else if (!matched_next)
                    begin
                        status = ST_BAD_SUM;
                    end
                    else
                    begin
                        status = ST_OK;
                    end
                    phase_next = PH_HUNT;
                    index_next = '0;
                end
                else
                begin
                    index_next = idx_p1[ByteW-1:0];
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                index_next = '0;
            end
        endcase

        res.frame_status = status;
        res.frame_len    = (phase_reg == PH_LEN) ? rx_byte : exp_len_reg;
        res.command      = command_next;
        res.ret_code     = ret_code_next;
        res.version      = version_next;
        res.func_id      = func_id_next;
        res.label_id     = label_id_next;
        res.box_x        = box_next[0];
        res.box_y        = box_next[1];
        res.box_w        = box_next[2];
        res.box_h        = box_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            index_reg    <= '0;
            exp_len_reg  <= '0;
            sum_reg      <= '0;
            matched_reg  <= 1'b0;
            command_reg  <= '0;
            ret_code_reg <= '0;
            version_reg  <= '0;
            func_id_reg  <= '0;
            label_id_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                box_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            exp_len_reg  <= exp_len_next;
            sum_reg      <= sum_next;
            matched_reg  <= matched_next;
            command_reg  <= command_next;
            ret_code_reg <= ret_code_next;
            version_reg  <= version_next;
            func_id_reg  <= func_id_next;
            label_id_reg <= label_id_next;
            for (int k = 0; k < 4; k++)
            begin
                box_reg[k] <= box_next[k];
            end
        end
    end

endmodule

// ===== design/serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Deframes a stream of received serial bytes (start, length, body, checksum,
// end) and delivers one status/field record per frame or bad length byte.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake             Payload
//  s_axis    in   s_tvalid / s_tready   s_tdata[7:0] = rx_byte
//  m_axis    out  m_tvalid / m_tready   m_tuser = frame_status, m_tdata = fields
//  cfg       in   cfg_valid / cfg_ready cfg_index (0 max len, 1 start, 2 end),
//                                       cfg_data
//
//  Each byte is held in the input register and makes one pass through the
//  parser into the result register, one byte per cycle sustained unless a
//  result waits. The result register is the only place a stall backs up from:
//  while a result waits for m_tready the parser holds, the input register
//  keeps its one byte and s_tready drops until the result is taken. Reset
//  clears the parser to hunting with all captures zero and loads the default
//  register values.
//  cfg_ready is always high; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter logic [ByteW-1:0] MAX_LEN_RST = DefMaxLen,
    parameter logic [ByteW-1:0] START_RST   = DefStart,
    parameter logic [ByteW-1:0] END_RST     = DefEnd
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ByteW-1:0]     s_tdata,      // [7:0] rx_byte

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ResDataW-1:0]  m_tdata,      // [7:0] frame_len, [15:8] command,
                                               // [23:16] ret_code, [55:24] version,
                                               // [63:56] func_id, [79:64] label_id,
                                               // [87:80] box_x, [95:88] box_y,
                                               // [103:96] box_w, [111:104] box_h
    output logic [StatusW-1:0]   m_tuser,      // [1:0] frame_status

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [ByteW-1:0]     cfg_data
);

    // Configuration registers
    cfg_t             cfg_reg;

    // Input register
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;

    // Result register
    logic             out_valid_reg;
    result_t          out_res_reg;

    logic             advance;
    logic             res_valid;
    result_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_len <= MAX_LEN_RST;
            cfg_reg.start_byte    <= START_RST;
            cfg_reg.end_byte      <= END_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_LEN: cfg_reg.max_frame_len <= cfg_data;
                CFG_START:   cfg_reg.start_byte    <= cfg_data;
                CFG_END:     cfg_reg.end_byte      <= cfg_data;
                default:     ;   // drop writes to unused indexes
            endcase
        end
    end

    // Advance the held byte when the result register can take what it makes
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    sfr_deframer u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load on a finished frame or bad length byte, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.frame_status;
    assign m_tdata  = {out_res_reg.box_h,
                       out_res_reg.box_w,
                       out_res_reg.box_y,
                       out_res_reg.box_x,
                       out_res_reg.label_id,
                       out_res_reg.func_id,
                       out_res_reg.version,
                       out_res_reg.ret_code,
                       out_res_reg.command,
                       out_res_reg.frame_len};

endmodule

// ===== sim/tb_serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver
// Self-checking bench for the serial frame deframer. Streams of start,
// length, body, checksum and end bytes go in under random source gaps and
// sink stalls. A behavioral parser in the bench predicts one record per
// frame or bad length byte. Each record that comes out is compared field by
// field with the oldest prediction. Directed frames cover the corner cases.
// Random traffic then runs under several register settings.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver;
    import sfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to wait after the last record so in-flight bytes settle.
    localparam int DrainCycles = 6;
    localparam int RandomPhases = 5;
    localparam int PhaseBytes = 250;
    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CfgIndexW-1:0] CfgUnused = 2'd3;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_SUM,
        FRAME_BAD_END,
        FRAME_BAD_BOTH,
        FRAME_CUT
    } frame_fault_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_START
    } body_fill_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [ByteW-1:0]     s_tdata = '0;       // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [ResDataW-1:0]  m_tdata;            // [7:0] frame_len, [15:8] command,
                                              // [23:16] ret_code, [55:24] version,
                                              // [63:56] func_id, [79:64] label_id,
                                              // [87:80] box_x, [95:88] box_y,
                                              // [103:96] box_w, [111:104] box_h
    logic [StatusW-1:0]   m_tuser;            // [1:0] frame_status
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [ByteW-1:0]     cfg_data = '0;

    // Parser shadow: register copy plus the parse state of the deframer.
    cfg_t             cfg_shadow = '{max_frame_len: DefMaxLen, start_byte: DefStart,
                                     end_byte: DefEnd};
    phase_t           parse_phase = PH_HUNT;
    logic [ByteW-1:0] byte_pos = '0;
    logic [ByteW-1:0] frame_len_q = '0;
    logic [ByteW-1:0] run_sum = '0;
    logic             sum_ok = 1'b0;
    result_t          held = '0;

    // Records predicted but not yet delivered, oldest first.
    result_t          expected_records[$];

    // Traffic shaping knobs, changed by the tests.
    bit               src_idle = 1'b1;
    bit               src_burst = 1'b0;
    int               sink_stall_pct = 0;
    int               stall_left = 0;

    int               error_count = 0;
    int               bytes_sent = 0;
    int               cfg_writes = 0;
    int               status_seen[4] = '{0, 0, 0, 0};

    serial_frame_receiver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void post_record(status_t st, logic [ByteW-1:0] len);
        result_t rec;
        rec = held;
        rec.frame_status = st;
        rec.frame_len = len;
        expected_records.push_back(rec);
    endfunction

    // Advance the parser shadow by one accepted byte; queue a record when the
    // byte closes a frame or is a rejected length byte.
    function automatic void deframe_byte(logic [ByteW-1:0] b);
        int      pos;
        int      len;
        status_t st;
        pos = int'(byte_pos);
        len = int'(frame_len_q);
        case (parse_phase)
            PH_HUNT:
            begin
                if (b == cfg_shadow.start_byte)
                begin
                    // Clear captures at a start byte found while hunting.
                    held = '0;
                    run_sum = '0;
                    sum_ok = 1'b0;
                    byte_pos = 8'd1;
                    frame_len_q = '0;
                    parse_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                frame_len_q = b;
                if (b > cfg_shadow.max_frame_len || b < MinLen)
                begin
                    post_record(ST_BAD_LEN, b);
                    parse_phase = PH_HUNT;
                    byte_pos = '0;
                end
                else
                begin
                    run_sum = b;
                    byte_pos = 8'd2;
                    parse_phase = PH_BODY;
                end
            end
            default:
            begin
                // Capture by fixed offset, even if the byte is the checksum or
                // the end byte of a short frame.
                case (pos)
                    2: held.command = b;
                    3: held.ret_code = b;
                    4, 5, 6, 7: held.version = held.version | (32'(b) << (8 * (pos - 4)));
                    8: held.func_id = b;
                    10: held.label_id[7:0] = b;
                    11: held.label_id[15:8] = b;
                    12: held.box_x = b;
                    13: held.box_y = b;
                    14: held.box_w = b;
                    15: held.box_h = b;
                    default: ;
                endcase
                if (pos + 3 <= len)
                    run_sum = run_sum + b;
                else if (pos + 2 == len)
                    sum_ok = (run_sum == b);
                if (pos + 1 >= len)
                begin
                    // A wrong end byte outranks a wrong checksum.
                    if (b != cfg_shadow.end_byte)
                        st = ST_BAD_END;
                    else if (!sum_ok)
                        st = ST_BAD_SUM;
                    else
                        st = ST_OK;
                    post_record(st, frame_len_q);
                    parse_phase = PH_HUNT;
                    byte_pos = '0;
                end
                else
                    byte_pos = byte_pos + 8'd1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Record checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            if (error_count < 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Sample at the edge: a record moves when m_tvalid and m_tready are high.
    always @(posedge clk)
    begin : record_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_records.size() == 0)
            begin
                if (error_count < 10)
                    $display("%0t: unexpected record, status %0d, length %0d",
                             $time, m_tuser, m_tdata[7:0]);
                error_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                check_field("frame_status", want.frame_status, m_tuser);
                check_field("frame_len", want.frame_len, m_tdata[7:0]);
                check_field("command", want.command, m_tdata[15:8]);
                check_field("ret_code", want.ret_code, m_tdata[23:16]);
                check_field("version", want.version, m_tdata[55:24]);
                check_field("func_id", want.func_id, m_tdata[63:56]);
                check_field("label_id", want.label_id, m_tdata[79:64]);
                check_field("box_x", want.box_x, m_tdata[87:80]);
                check_field("box_y", want.box_y, m_tdata[95:88]);
                check_field("box_w", want.box_w, m_tdata[103:96]);
                check_field("box_h", want.box_h, m_tdata[111:104]);
                status_seen[want.frame_status]++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Traffic shaping
    // ------------------------------------------------------------------------

    // Mostly short idles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int src_gap();
        if (!src_idle || src_burst || $urandom_range(0, 99) < 60)
            return 0;
        return idle_len();
    endfunction

    // Sink side: drop m_tready for random stretches.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < sink_stall_pct)
        begin
            m_tready <= 1'b0;
            stall_left <= idle_len() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until the transaction completes. Keep
    // s_tvalid high across back-to-back bytes; drop it only for a gap.
    task automatic send_byte(logic [ByteW-1:0] b);
        int gap;
        gap = src_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= ByteW'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [ByteW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MAX_LEN: cfg_shadow.max_frame_len = value;
            CFG_START:   cfg_shadow.start_byte = value;
            CFG_END:     cfg_shadow.end_byte = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_config(logic [ByteW-1:0] max_len, logic [ByteW-1:0] sob,
                                logic [ByteW-1:0] eob);
        cfg_write(CFG_MAX_LEN, max_len);
        cfg_write(CFG_START, sob);
        cfg_write(CFG_END, eob);
        cfg_valid <= 1'b0;
    endtask

    // Hold the source, drain every predicted record, then let the pipeline
    // settle so bytes that make no record are also through.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Build a frame with length byte n under the current registers and send
    // it. A length the block rejects sends only start and length bytes.
    task automatic send_frame(int n, frame_fault_t fault, body_fill_t fill);
        logic [ByteW-1:0] frame_bytes[$];
        logic [ByteW-1:0] csum;
        logic [ByteW-1:0] b;
        int               count;
        frame_bytes.push_back(cfg_shadow.start_byte);
        frame_bytes.push_back(ByteW'(n));
        if (n >= int'(MinLen) && n <= int'(cfg_shadow.max_frame_len))
        begin
            csum = ByteW'(n);
            for (int i = 2; i < n - 2; i++)
            begin
                case (fill)
                    FILL_ZERO:  b = '0;
                    FILL_ONES:  b = '1;
                    FILL_START: b = cfg_shadow.start_byte;
                    default:    b = ByteW'($urandom);
                endcase
                frame_bytes.push_back(b);
                csum = csum + b;
            end
            frame_bytes.push_back(csum);
            frame_bytes.push_back(cfg_shadow.end_byte);
            if (fault == FRAME_BAD_SUM || fault == FRAME_BAD_BOTH)
                frame_bytes[n - 2] = frame_bytes[n - 2] ^ ByteW'($urandom_range(1, 255));
            if (fault == FRAME_BAD_END || fault == FRAME_BAD_BOTH)
                frame_bytes[n - 1] = frame_bytes[n - 1] ^ ByteW'($urandom_range(1, 255));
        end
        count = frame_bytes.size();
        // A cut frame stops early; the next bytes are taken as its body.
        if (fault == FRAME_CUT && count > 2)
            count = $urandom_range(2, count - 1);
        for (int i = 0; i < count; i++)
            send_byte(frame_bytes[i]);
    endtask

    task automatic send_random_frame();
        int               r;
        int               n;
        int               max_len;
        frame_fault_t     fault;
        body_fill_t       fill;
        logic [ByteW-1:0] noise;
        max_len = int'(cfg_shadow.max_frame_len);
        // Some frames go through with no source gaps at all.
        src_burst = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, 4))
            begin
                noise = ByteW'($urandom);
                if (noise == cfg_shadow.start_byte && $urandom_range(0, 9) != 0)
                    noise = ~noise;
                send_byte(noise);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 8)
            n = (max_len < 255 && r[0]) ? $urandom_range(max_len + 1, 255)
                                        : $urandom_range(0, int'(MinLen) - 1);
        else if (r < 12)
            n = max_len;
        else if (r < 15)
            n = $urandom_range(int'(MinLen), max_len);
        else
            n = $urandom_range(int'(MinLen), (max_len < 20) ? max_len : 20);
        r = $urandom_range(0, 99);
        if (r < 8)
            fault = FRAME_BAD_SUM;
        else if (r < 16)
            fault = FRAME_BAD_END;
        else if (r < 19)
            fault = FRAME_BAD_BOTH;
        else if (r < 24)
            fault = FRAME_CUT;
        else
            fault = FRAME_CLEAN;
        fill = ($urandom_range(0, 99) < 5) ? FILL_START : FILL_RANDOM;
        send_frame(n, fault, fill);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner frames under the reset register values.
    task automatic test_frame_basics();
        src_idle = 1'b1;
        sink_stall_pct = 30;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16, FRAME_CLEAN, FILL_RANDOM);
        send_frame(16, FRAME_CLEAN, FILL_ONES);
        send_frame(16, FRAME_CLEAN, FILL_ZERO);
        // Short frames: checksum and end land on capture offsets.
        send_frame(4, FRAME_CLEAN, FILL_RANDOM);
        send_frame(5, FRAME_CLEAN, FILL_RANDOM);
        send_frame(9, FRAME_CLEAN, FILL_RANDOM);
        send_frame(12, FRAME_CLEAN, FILL_RANDOM);
        // Lengths under the minimum and over the limit.
        send_frame(3, FRAME_CLEAN, FILL_RANDOM);
        send_frame(0, FRAME_CLEAN, FILL_RANDOM);
        send_frame(65, FRAME_CLEAN, FILL_RANDOM);
        send_frame(255, FRAME_CLEAN, FILL_RANDOM);
        send_frame(int'(DefMaxLen), FRAME_CLEAN, FILL_RANDOM);
        send_frame(20, FRAME_BAD_SUM, FILL_RANDOM);
        send_frame(20, FRAME_BAD_END, FILL_RANDOM);
        send_frame(20, FRAME_BAD_BOTH, FILL_RANDOM);
        // Start byte in the body is plain data.
        send_frame(18, FRAME_CLEAN, FILL_START);
        send_frame(14, FRAME_CUT, FILL_RANDOM);
        send_frame(10, FRAME_CLEAN, FILL_RANDOM);
        wait_idle();
    endtask

    // Register extremes, an unused index, limits below the minimum length,
    // and start equal to end.
    task automatic test_register_settings();
        apply_config(8'd255, 8'h00, 8'hFF);
        send_frame(255, FRAME_CLEAN, FILL_RANDOM);
        send_frame(4, FRAME_CLEAN, FILL_RANDOM);
        send_frame(0, FRAME_CLEAN, FILL_RANDOM);
        send_frame(40, FRAME_BAD_END, FILL_RANDOM);
        wait_idle();
        cfg_write(CfgUnused, ByteW'($urandom));
        cfg_valid <= 1'b0;
        send_frame(10, FRAME_CLEAN, FILL_RANDOM);
        wait_idle();
        // Limit under the minimum: every length is rejected.
        apply_config(8'd3, DefStart, DefEnd);
        send_frame(3, FRAME_CLEAN, FILL_RANDOM);
        send_frame(4, FRAME_CLEAN, FILL_RANDOM);
        send_frame(200, FRAME_CLEAN, FILL_RANDOM);
        wait_idle();
        apply_config(8'd0, 8'hAA, 8'h55);
        send_frame(0, FRAME_CLEAN, FILL_RANDOM);
        wait_idle();
        apply_config(MinLen, 8'hAA, 8'h55);
        send_frame(4, FRAME_CLEAN, FILL_RANDOM);
        send_frame(5, FRAME_CLEAN, FILL_RANDOM);
        send_frame(4, FRAME_BAD_SUM, FILL_RANDOM);
        wait_idle();
        apply_config(8'd16, 8'h5A, 8'h5A);
        send_frame(8, FRAME_CLEAN, FILL_RANDOM);
        send_frame(16, FRAME_CLEAN, FILL_START);
        wait_idle();
    endtask

    // Mostly well-formed frames with random content, mixed with noise, bad
    // lengths, corrupted and cut frames, across several settings.
    task automatic test_random_traffic();
        int budget_end;
        for (int p = 0; p < RandomPhases; p++)
        begin
            case (p)
                0:
                begin
                    src_idle = 1'b1;
                    sink_stall_pct = 25;
                    apply_config(DefMaxLen, DefStart, DefEnd);
                end
                1:
                begin
                    // No idling on either side.
                    src_idle = 1'b0;
                    sink_stall_pct = 0;
                    apply_config(8'd255, 8'h00, 8'hFF);
                end
                2:
                begin
                    src_idle = 1'b1;
                    sink_stall_pct = 50;
                    apply_config(ByteW'($urandom_range(4, 40)), ByteW'($urandom),
                                 ByteW'($urandom));
                end
                3:
                begin
                    src_idle = 1'b0;
                    sink_stall_pct = 30;
                    apply_config(ByteW'($urandom_range(4, 255)), ByteW'($urandom),
                                 ByteW'($urandom));
                end
                default:
                begin
                    src_idle = 1'b1;
                    sink_stall_pct = 0;
                    apply_config(8'd24, ByteW'($urandom), ByteW'($urandom));
                end
            endcase
            budget_end = bytes_sent + PhaseBytes;
            while (bytes_sent < budget_end)
                send_random_frame();
            src_burst = 1'b0;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_basics();
        test_register_settings();
        test_random_traffic();

        if (expected_records.size() != 0)
        begin
            $display("%0d records never arrived", expected_records.size());
            error_count += expected_records.size();
        end

        $display("Sent %0d bytes with %0d register writes over reset, extreme and random settings.",
                 bytes_sent, cfg_writes);
        $display("Records checked: %0d ok, %0d bad end, %0d bad checksum, %0d bad length.",
                 status_seen[ST_OK], status_seen[ST_BAD_END], status_seen[ST_BAD_SUM],
                 status_seen[ST_BAD_LEN]);
        if (error_count == 0)
            $display("tb_serial_frame_receiver passed");
        else
            $display("tb_serial_frame_receiver failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #10ms;
        $display("Timeout with %0d records outstanding", expected_records.size());
        $display("tb_serial_frame_receiver failed");
        $finish;
    end

endmodule
